// ----- sv/rchpf_pkg.sv -----
// shared types, constants and helpers for the hopping packet framer
package rchpf_pkg;

    typedef enum logic
    {
        CMD_INIT = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        REG_TX_ID          = 2'd0,
        REG_V1_MODE        = 2'd1,
        REG_BIND_MODE      = 2'd2,
        REG_CHANNEL_CENTER = 2'd3
    } reg_idx_t;

    localparam int HOP_CHANNELS = 3;
    localparam int PKT_BYTES    = 18;
    localparam int NUM_CH       = 8;
    localparam int CH_W         = 12;

    localparam logic [1:0] POS_LAST = 2'(HOP_CHANNELS - 1);

    localparam logic [7:0] HDR_DATA      = 8'h10;
    localparam logic [7:0] HDR_ID        = 8'h07;
    localparam logic [7:0] HDR_BIND_ID   = 8'h04;
    localparam logic [7:0] HDR_BIND_HOP  = 8'h03;
    localparam logic [7:0] BIND_V1_TAIL  = 8'hCD;
    localparam logic [7:0] ID_BYTE1      = 8'hFE;
    localparam logic [7:0] DATA_V2_TAIL  = 8'h03;
    localparam logic [7:0] RF_BIND_V1    = 8'hD1;
    localparam logic [7:0] RF_BIND_V2    = 8'hB8;
    localparam logic [7:0] RF_ID         = 8'h00;

    localparam logic [14:0] PERIOD_DATA_SHORT = 15'd4000;
    localparam logic [14:0] PERIOD_DATA_LONG  = 15'd12000;
    localparam logic [14:0] PERIOD_ID         = 15'd6500;
    localparam logic [14:0] PERIOD_BIND_V1    = 15'd3500;
    localparam logic [14:0] PERIOD_BIND_V2    = 15'd25000;
    localparam logic [14:0] MIX_NONE          = 15'd0;
    localparam logic [14:0] MIX_BIND_V1       = 15'd14000;
    localparam logic [14:0] MIX_BIND_V2       = 15'd25000;
    localparam logic [14:0] MIX_ID_ODD        = 15'd13000;
    localparam logic [14:0] MIX_DATA_FIRST    = 15'd20000;

    localparam logic [8:0] ID_PACKET_COUNT = 9'd400;

    localparam logic signed [13:0] CLAMP_LO = -14'sd860;
    localparam logic signed [13:0] CLAMP_HI = 14'sd2140;

    localparam logic [4:0] LAST_BIND_HOP = 5'd4;
    localparam logic [4:0] LAST_BIND_ID  = 5'd5;
    localparam logic [4:0] LAST_ID       = 5'd8;
    localparam logic [4:0] LAST_DATA     = 5'd17;

    typedef struct packed
    {
        logic [31:0] tx_id;
        logic        v1_mode;
        logic        bind_mode;
        logic [11:0] channel_center;
    } cfg_t;

    typedef struct packed
    {
        logic [PKT_BYTES-1:0][7:0] data;
        logic [4:0]                last_idx;
        logic [7:0]                rf_channel;
        logic [14:0]               period_us;
        logic [14:0]               mixer_hint_us;
    } pkt_t;

    // remainder by 39 of one byte, three conditional subtracts
    function automatic logic [7:0] mod39(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (r >= 8'd156)
        begin
            r = r - 8'd156;
        end
        if (r >= 8'd78)
        begin
            r = r - 8'd78;
        end
        if (r >= 8'd39)
        begin
            r = r - 8'd39;
        end
        return r;
    endfunction

endpackage

// ----- sv/rchpf_cfg.sv -----
// configuration registers written through the plain write port
module rchpf_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output rchpf_pkg::cfg_t    cfg
);

    rchpf_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tx_id          <= 32'd0;
            cfg_reg.v1_mode        <= 1'b1;
            cfg_reg.bind_mode      <= 1'b0;
            cfg_reg.channel_center <= 12'd1500;
        end
        else if (cfg_we)
        begin
            case (rchpf_pkg::reg_idx_t'(cfg_index))
                rchpf_pkg::REG_TX_ID:          cfg_reg.tx_id          <= cfg_data;
                rchpf_pkg::REG_V1_MODE:        cfg_reg.v1_mode        <= cfg_data[0];
                rchpf_pkg::REG_BIND_MODE:      cfg_reg.bind_mode      <= cfg_data[0];
                rchpf_pkg::REG_CHANNEL_CENTER: cfg_reg.channel_center <= cfg_data[11:0];
                default:                       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/rchpf_build.sv -----
// link state and single-pass packet builder
module rchpf_build
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      accept,
    input  logic                                      cmd,
    input  logic [rchpf_pkg::NUM_CH*rchpf_pkg::CH_W-1:0] chans,
    input  rchpf_pkg::cfg_t                           cfg,
    output rchpf_pkg::pkt_t                           pkt
);

    logic [3:0][7:0] hop_reg;
    logic [3:0][7:0] hop_next;
    logic [31:0]     id_reg;
    logic [31:0]     id_next;
    logic [1:0]      pos_reg;
    logic [1:0]      pos_next;
    logic            toggle_reg;
    logic            toggle_next;
    logic [8:0]      left_reg;
    logic [8:0]      left_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg    <= '0;
            id_reg     <= '0;
            pos_reg    <= '0;
            toggle_reg <= 1'b0;
            left_reg   <= '0;
        end
        else if (accept)
        begin
            hop_reg    <= hop_next;
            id_reg     <= id_next;
            pos_reg    <= pos_next;
            toggle_reg <= toggle_next;
            left_reg   <= left_next;
        end
    end

    // state update
    always_comb
    begin
        logic [3:0][7:0] b;
        logic [1:0]      order;
        hop_next    = hop_reg;
        id_next     = id_reg;
        pos_next    = pos_reg;
        toggle_next = toggle_reg;
        left_next   = left_reg;
        b           = cfg.tx_id;
        order       = b[3][1:0];
        if (rchpf_pkg::cmd_t'(cmd) == rchpf_pkg::CMD_INIT)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hop_next[2'(i) ^ order] = 8'd2 + rchpf_pkg::mod39(b[3-i]) + 8'(40 * i);
            end
            if (b[3][0])
            begin
                b[0][0] = 1'b1;
                b[2][0] = 1'b0;
            end
            else
            begin
                b[0][0] = 1'b0;
                b[2][0] = 1'b1;
            end
            b[1]        = rchpf_pkg::ID_BYTE1;
            id_next     = b;
            toggle_next = 1'b0;
            pos_next    = 2'd0;
            left_next   = cfg.v1_mode ? 9'd0 : rchpf_pkg::ID_PACKET_COUNT;
        end
        else if (cfg.bind_mode)
        begin
            if (cfg.v1_mode)
            begin
                toggle_next = ~toggle_reg;
            end
        end
        else if (left_reg != 9'd0)
        begin
            left_next = left_reg - 9'd1;
        end
        else
        begin
            pos_next = (pos_reg >= rchpf_pkg::POS_LAST) ? 2'd0 : pos_reg + 2'd1;
        end
    end

    // packet contents for a tick
    always_comb
    begin
        logic signed [12:0] chx;
        logic signed [11:0] half;
        logic signed [13:0] v;
        logic [8:0]         left_dec;
        pkt      = '0;
        chx      = '0;
        half     = '0;
        v        = '0;
        left_dec = left_reg - 9'd1;
        if (cfg.bind_mode)
        begin
            if (cfg.v1_mode)
            begin
                pkt.rf_channel = rchpf_pkg::RF_BIND_V1;
                pkt.period_us  = rchpf_pkg::PERIOD_BIND_V1;
                if (toggle_reg)
                begin
                    pkt.data[0] = rchpf_pkg::HDR_BIND_ID;
                    for (int i = 0; i < 4; i++)
                    begin
                        pkt.data[i+1] = id_reg[8*i +: 8];
                    end
                    pkt.data[5]       = rchpf_pkg::BIND_V1_TAIL;
                    pkt.last_idx      = rchpf_pkg::LAST_BIND_ID;
                    pkt.mixer_hint_us = rchpf_pkg::MIX_BIND_V1;
                end
                else
                begin
                    pkt.data[0] = rchpf_pkg::HDR_BIND_HOP;
                    for (int i = 0; i < 4; i++)
                    begin
                        pkt.data[i+1] = hop_reg[i];
                    end
                    pkt.last_idx      = rchpf_pkg::LAST_BIND_HOP;
                    pkt.mixer_hint_us = rchpf_pkg::MIX_NONE;
                end
            end
            else
            begin
                pkt.data[0] = rchpf_pkg::HDR_BIND_ID;
                for (int i = 0; i < 4; i++)
                begin
                    pkt.data[i+1] = id_reg[8*i +: 8];
                end
                pkt.last_idx      = rchpf_pkg::LAST_BIND_ID;
                pkt.rf_channel    = rchpf_pkg::RF_BIND_V2;
                pkt.period_us     = rchpf_pkg::PERIOD_BIND_V2;
                pkt.mixer_hint_us = rchpf_pkg::MIX_BIND_V2;
            end
        end
        else if (left_reg != 9'd0)
        begin
            pkt.data[0] = rchpf_pkg::HDR_ID;
            for (int i = 0; i < rchpf_pkg::HOP_CHANNELS; i++)
            begin
                pkt.data[i+1] = hop_reg[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                pkt.data[i+4] = id_reg[8*i +: 8];
            end
            pkt.last_idx      = rchpf_pkg::LAST_ID;
            pkt.rf_channel    = rchpf_pkg::RF_ID;
            pkt.period_us     = rchpf_pkg::PERIOD_ID;
            pkt.mixer_hint_us = left_dec[0] ? rchpf_pkg::MIX_ID_ODD : rchpf_pkg::MIX_NONE;
        end
        else
        begin
            pkt.data[0] = rchpf_pkg::HDR_DATA;
            for (int i = 0; i < rchpf_pkg::NUM_CH; i++)
            begin
                // halve toward zero, add centre, clamp
                chx  = {chans[i*rchpf_pkg::CH_W + rchpf_pkg::CH_W-1],
                        chans[i*rchpf_pkg::CH_W +: rchpf_pkg::CH_W]}
                       + {12'd0, chans[i*rchpf_pkg::CH_W + rchpf_pkg::CH_W-1]};
                half = chx[12:1];
                v    = {{2{half[11]}}, half} + {2'b00, cfg.channel_center};
                if (v < rchpf_pkg::CLAMP_LO)
                begin
                    v = rchpf_pkg::CLAMP_LO;
                end
                if (v > rchpf_pkg::CLAMP_HI)
                begin
                    v = rchpf_pkg::CLAMP_HI;
                end
                pkt.data[i+1] = v[7:0];
                pkt.data[9 + i/2][4*(i%2) +: 4] = v[11:8];
            end
            for (int i = 0; i < 4; i++)
            begin
                pkt.data[i+13] = id_reg[8*i +: 8];
            end
            pkt.last_idx   = rchpf_pkg::LAST_DATA;
            pkt.rf_channel = hop_reg[pos_reg];
            case (pos_reg)
                2'd0:
                begin
                    pkt.period_us     = rchpf_pkg::PERIOD_DATA_SHORT;
                    pkt.mixer_hint_us = rchpf_pkg::MIX_DATA_FIRST;
                end
                2'd1:
                begin
                    pkt.period_us     = rchpf_pkg::PERIOD_DATA_SHORT;
                    pkt.mixer_hint_us = rchpf_pkg::MIX_NONE;
                end
                default:
                begin
                    pkt.period_us     = rchpf_pkg::PERIOD_DATA_LONG;
                    pkt.mixer_hint_us = rchpf_pkg::MIX_NONE;
                    if (!cfg.v1_mode)
                    begin
                        pkt.data[17] = rchpf_pkg::DATA_V2_TAIL;
                    end
                end
            endcase
        end
    end

endmodule

// ----- sv/rchpf_tx.sv -----
// packet register and byte serializer
module rchpf_tx
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  rchpf_pkg::pkt_t pkt,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic            m_tlast,
    output logic [7:0]      data_byte,
    output logic [7:0]      rf_channel,
    output logic [14:0]     period_us,
    output logic [14:0]     mixer_hint_us
);

    rchpf_pkg::pkt_t pkt_reg;
    logic            valid_reg;
    logic [4:0]      idx_reg;
    logic            last;

    assign last = (idx_reg == pkt_reg.last_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && m_tready)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg <= pkt;
        end
    end

    assign m_tvalid      = valid_reg;
    assign m_tlast       = last;
    assign data_byte     = pkt_reg.data[idx_reg];
    assign rf_channel    = pkt_reg.rf_channel;
    assign period_us     = pkt_reg.period_us;
    assign mixer_hint_us = pkt_reg.mixer_hint_us;

endmodule

// ----- sv/rc_hopping_packet_framer.sv -----
// top level of the hopping radio-control packet framer
//
//  port group   dir  fields
//  s_*          in   tuser: command; tdata: ch0..ch7, 12 bits each
//  m_*          out  tlast: last_byte; tdata: byte, rf channel, period, mixer hint
//  cfg_*        in   write enable, register index, write data
//
// a tick is built in the cycle it is accepted and stored whole; its bytes
// then leave one per beat, 5 to 18 bytes per packet
// the next item is taken in the same cycle as the last byte of the packet
// init items give no bytes and are accepted whenever the output is free
// a stalled output holds the current byte; reset clears state, no sweep
module rc_hopping_packet_framer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // ch0 .. ch7, 12 bits each
    input  logic [0:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // data_byte, rf_channel, period_us, mixer_hint_us, pad
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    rchpf_pkg::cfg_t cfg;
    rchpf_pkg::pkt_t pkt;
    logic            accept;
    logic            load;
    logic [7:0]      data_byte;
    logic [7:0]      rf_channel;
    logic [14:0]     period_us;
    logic [14:0]     mixer_hint_us;

    assign s_tready = !m_tvalid || (m_tready && m_tlast);
    assign accept   = s_tvalid && s_tready;
    assign load     = accept && (rchpf_pkg::cmd_t'(s_tuser[0]) == rchpf_pkg::CMD_TICK);

    rchpf_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rchpf_build u_build
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (s_tuser[0]),
        .chans  (s_tdata),
        .cfg    (cfg),
        .pkt    (pkt)
    );

    rchpf_tx u_tx
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .pkt           (pkt),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tlast       (m_tlast),
        .data_byte     (data_byte),
        .rf_channel    (rf_channel),
        .period_us     (period_us),
        .mixer_hint_us (mixer_hint_us)
    );

    assign m_tdata = {2'b00, mixer_hint_us, period_us, rf_channel, data_byte};

`ifndef SYNTHESIS
    a_idle_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output is empty");

    a_tick_out : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> m_tvalid)
        else $error("tick accepted but no packet followed");

    a_init_silent : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0] && !m_tvalid) |=> !m_tvalid)
        else $error("init produced output bytes");
`endif

endmodule

// ----- test/tb_rc_hopping_packet_framer.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the hopping radio-control packet framer
module tb_rc_hopping_packet_framer;

    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 40;

    localparam logic [7:0]  HDR_DATA_PKT  = 8'h10;
    localparam logic [7:0]  HDR_ID_PKT    = 8'h07;
    localparam logic [7:0]  HDR_BIND_ID   = 8'h04;
    localparam logic [7:0]  HDR_BIND_HOPS = 8'h03;
    localparam logic [7:0]  TAIL_BIND_V1  = 8'hCD;
    localparam logic [7:0]  TAIL_DATA_V2  = 8'h03;
    localparam logic [7:0]  RF_V1_BIND    = 8'hD1;
    localparam logic [7:0]  RF_V2_BIND    = 8'hB8;
    localparam logic [7:0]  RF_ID_PKT     = 8'h00;
    localparam logic [14:0] US_DATA_SHORT = 15'd4000;
    localparam logic [14:0] US_DATA_LONG  = 15'd12000;
    localparam logic [14:0] US_ID_PKT     = 15'd6500;
    localparam logic [14:0] US_V1_BIND    = 15'd3500;
    localparam logic [14:0] US_V2_BIND    = 15'd25000;
    localparam logic [14:0] US_MIX_V1_ID  = 15'd14000;
    localparam logic [14:0] US_MIX_ID_ODD = 15'd13000;
    localparam logic [14:0] US_MIX_FIRST  = 15'd20000;
    localparam logic [14:0] US_NO_MIX     = 15'd0;
    localparam int          ID_BURST      = 400;
    localparam int          CLAMP_MIN     = -860;
    localparam int          CLAMP_MAX     = 2140;

    typedef struct packed
    {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [7:0]  rf_channel;
        logic [14:0] period_us;
        logic [14:0] mixer_hint_us;
    } air_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // register copies
    logic [31:0] reg_tx_id = '0;
    logic        reg_v1 = 1'b1;
    logic        reg_bind = 1'b0;
    logic [11:0] reg_center = 12'd1500;

    // framer state
    logic [7:0]  hop_tab [4] = '{default: '0};
    logic [31:0] fixed_id = '0;
    logic [1:0]  hop_pos = '0;
    logic        bind_phase = 1'b0;
    logic [8:0]  id_pkts_left = '0;

    air_byte_t pending_bytes [$];
    int        errors = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;

    rc_hopping_packet_framer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void queue_packet(input logic [17:0][7:0] pkt, input int len,
                                         input logic [7:0] rf, input logic [14:0] period,
                                         input logic [14:0] mixer);
        air_byte_t b;
        for (int k = 0; k < len; k++)
        begin
            b.data_byte     = pkt[k];
            b.last_byte     = (k == len - 1);
            b.rf_channel    = rf;
            b.period_us     = period;
            b.mixer_hint_us = mixer;
            pending_bytes.push_back(b);
        end
    endfunction

    function automatic void build_hop_table();
        logic [3:0][7:0] b;
        logic [1:0]      order;
        b     = reg_tx_id;
        order = b[3][1:0];
        for (int i = 0; i < 4; i++)
        begin
            hop_tab[2'(i) ^ order] = 8'(2 + int'(b[3 - i]) % 39 + 40 * i);
        end
        // parity rule on id bytes 0 and 2 follows bit 0 of byte 3
        b[0][0] = b[3][0];
        b[2][0] = ~b[3][0];
        b[1]    = 8'hFE;
        fixed_id     = b;
        bind_phase   = 1'b0;
        hop_pos      = 2'd0;
        id_pkts_left = reg_v1 ? 9'd0 : 9'(ID_BURST);
    endfunction

    function automatic void frame_tick(input logic [95:0] chans);
        logic [17:0][7:0]   pkt;
        logic [3:0][7:0]    idb;
        logic signed [11:0] raw;
        logic [1:0]         pos;
        logic [14:0]        period;
        logic [14:0]        mixer;
        int                 v;
        pkt = '0;
        idb = fixed_id;
        if (reg_bind)
        begin
            if (reg_v1)
            begin
                if (bind_phase)
                begin
                    pkt[0]   = HDR_BIND_ID;
                    pkt[4:1] = idb;
                    pkt[5]   = TAIL_BIND_V1;
                    queue_packet(pkt, 6, RF_V1_BIND, US_V1_BIND, US_MIX_V1_ID);
                end
                else
                begin
                    pkt[0] = HDR_BIND_HOPS;
                    for (int i = 0; i < 4; i++)
                    begin
                        pkt[i + 1] = hop_tab[i];
                    end
                    queue_packet(pkt, 5, RF_V1_BIND, US_V1_BIND, US_NO_MIX);
                end
                bind_phase = ~bind_phase;
            end
            else
            begin
                pkt[0]   = HDR_BIND_ID;
                pkt[4:1] = idb;
                queue_packet(pkt, 6, RF_V2_BIND, US_V2_BIND, US_V2_BIND);
            end
        end
        else if (id_pkts_left != 0)
        begin
            id_pkts_left = id_pkts_left - 9'd1;
            pkt[0] = HDR_ID_PKT;
            for (int i = 0; i < 3; i++)
            begin
                pkt[i + 1] = hop_tab[i];
            end
            pkt[7:4] = idb;
            queue_packet(pkt, 9, RF_ID_PKT, US_ID_PKT,
                         id_pkts_left[0] ? US_MIX_ID_ODD : US_NO_MIX);
        end
        else
        begin
            pkt[0] = HDR_DATA_PKT;
            for (int i = 0; i < 8; i++)
            begin
                raw = chans[12 * i +: 12];
                v   = int'(raw) / 2 + int'(reg_center);
                if (v < CLAMP_MIN)
                begin
                    v = CLAMP_MIN;
                end
                if (v > CLAMP_MAX)
                begin
                    v = CLAMP_MAX;
                end
                pkt[i + 1] = v[7:0];
                if (i % 2 == 1)
                begin
                    pkt[9 + i / 2][7:4] = v[11:8];
                end
                else
                begin
                    pkt[9 + i / 2][3:0] = v[11:8];
                end
            end
            pkt[16:13] = idb;
            pos    = hop_pos;
            period = (pos >= 2'd2) ? US_DATA_LONG : US_DATA_SHORT;
            mixer  = (pos == 2'd0) ? US_MIX_FIRST : US_NO_MIX;
            if (pos >= 2'd2 && !reg_v1)
            begin
                pkt[17] = TAIL_DATA_V2;
            end
            hop_pos = (pos >= 2'd2) ? 2'd0 : pos + 2'd1;
            queue_packet(pkt, 18, hop_tab[pos], period, mixer);
        end
    endfunction

    function automatic logic [11:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 12'h800;
            1: return 12'h7FF;
            2, 3: return 12'(int'($urandom_range(0, 2560)) - 1280);
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [95:0] rand_chans();
        logic [95:0] w;
        for (int i = 0; i < 8; i++)
        begin
            w[12 * i +: 12] = rand_chan();
        end
        return w;
    endfunction

    function automatic logic [31:0] rand_tx_id();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] rand_center();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'd4095;
            2, 3: return 12'd1500;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    task automatic send_item(input rchpf_pkg::cmd_t cmd, input logic [95:0] chans);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= chans;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (cmd == rchpf_pkg::CMD_INIT)
        begin
            build_hop_table();
        end
        else
        begin
            frame_tick(chans);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] tx_id, input logic v1, input logic bind_en,
                                input logic [11:0] center);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= rchpf_pkg::REG_TX_ID;
        cfg_data  <= tx_id;
        @(posedge clk);
        cfg_index <= rchpf_pkg::REG_V1_MODE;
        cfg_data  <= {31'd0, v1};
        @(posedge clk);
        cfg_index <= rchpf_pkg::REG_BIND_MODE;
        cfg_data  <= {31'd0, bind_en};
        @(posedge clk);
        cfg_index <= rchpf_pkg::REG_CHANNEL_CENTER;
        cfg_data  <= {20'd0, center};
        @(posedge clk);
        cfg_we     <= 1'b0;
        reg_tx_id  = tx_id;
        reg_v1     = v1;
        reg_bind   = bind_en;
        reg_center = center;
    endtask

    // data packets straight out of reset, all-zero hop table and id
    task automatic test_reset_state();
        send_item(rchpf_pkg::CMD_TICK, '0);
        send_item(rchpf_pkg::CMD_TICK, {8{12'h7FF}});
        send_item(rchpf_pkg::CMD_TICK, {8{12'h800}});
    endtask

    task automatic test_v1_data();
        program_regs(32'h5A3C_81F7, 1'b1, 1'b0, 12'd1500);
        send_item(rchpf_pkg::CMD_INIT, '0);
        send_item(rchpf_pkg::CMD_TICK, {4{12'h7FF, 12'h800}});
        send_item(rchpf_pkg::CMD_TICK, {4{12'd1280, 12'hB00}});
        send_item(rchpf_pkg::CMD_TICK, {12'h001, 12'hFFF, 12'h555, 12'hAAA,
                                        12'h123, 12'hEDC, 12'h400, 12'hC00});
    endtask

    task automatic test_clamp();
        program_regs(32'hFFFF_FFFF, 1'b1, 1'b0, 12'd0);
        send_item(rchpf_pkg::CMD_INIT, '0);
        send_item(rchpf_pkg::CMD_TICK, {8{12'h800}});
        program_regs(32'hFFFF_FFFF, 1'b1, 1'b0, 12'd4095);
        send_item(rchpf_pkg::CMD_TICK, {8{12'h7FF}});
        send_item(rchpf_pkg::CMD_TICK, {8{12'hFFF}});
    endtask

    task automatic test_bind();
        program_regs(32'h0000_0000, 1'b1, 1'b1, 12'd1500);
        send_item(rchpf_pkg::CMD_INIT, '0);
        repeat (3) send_item(rchpf_pkg::CMD_TICK, rand_chans());
        program_regs(32'h0100_0000, 1'b0, 1'b1, 12'd1500);
        send_item(rchpf_pkg::CMD_INIT, '0);
        send_item(rchpf_pkg::CMD_TICK, rand_chans());
    endtask

    task automatic test_id_packets();
        program_regs(32'h03A7_12C4, 1'b0, 1'b0, 12'd1500);
        send_item(rchpf_pkg::CMD_INIT, '0);
        repeat (3) send_item(rchpf_pkg::CMD_TICK, rand_chans());
    endtask

    // init under version one, then switch to version two for the hop tail byte
    task automatic test_v2_data();
        program_regs(32'h8E21_D00B, 1'b1, 1'b0, 12'd2048);
        send_item(rchpf_pkg::CMD_INIT, '0);
        program_regs(32'h8E21_D00B, 1'b0, 1'b0, 12'd2048);
        repeat (3) send_item(rchpf_pkg::CMD_TICK, rand_chans());
    endtask

    task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
        int sent;
        int burst;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                program_regs(rand_tx_id(), $urandom_range(0, 9) < 6,
                             $urandom_range(0, 3) == 0, rand_center());
            end
            if ($urandom_range(0, 2) == 0)
            begin
                send_item(rchpf_pkg::CMD_INIT, rand_chans());
                sent++;
            end
            burst = $urandom_range(1, 10);
            repeat (burst)
            begin
                send_item(($urandom_range(0, 15) == 0) ? rchpf_pkg::CMD_INIT
                                                        : rchpf_pkg::CMD_TICK,
                          rand_chans());
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin : beat_check
        air_byte_t got;
        air_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.data_byte     = m_tdata[7:0];
            got.last_byte     = m_tlast;
            got.rf_channel    = m_tdata[15:8];
            got.period_us     = m_tdata[30:16];
            got.mixer_hint_us = m_tdata[45:31];
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("beat with nothing pending, data_byte", got.data_byte, 0);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (got.data_byte != want.data_byte)
                begin
                    report_mismatch("data_byte", got.data_byte, want.data_byte);
                end
                if (got.last_byte != want.last_byte)
                begin
                    report_mismatch("last_byte", got.last_byte, want.last_byte);
                end
                if (got.rf_channel != want.rf_channel)
                begin
                    report_mismatch("rf_channel", got.rf_channel, want.rf_channel);
                end
                if (got.period_us != want.period_us)
                begin
                    report_mismatch("period_us", got.period_us, want.period_us);
                end
                if (got.mixer_hint_us != want.mixer_hint_us)
                begin
                    report_mismatch("mixer_hint_us", got.mixer_hint_us, want.mixer_hint_us);
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_v1_data();
        test_clamp();
        test_bind();
        test_id_packets();
        test_v2_data();
        test_random(112, 33, 87);
        test_random(112, 87, 33);
        test_random(110, 0, 0);
        wait_idle();
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/rchpf_pkg.sv
sv/rchpf_cfg.sv
sv/rchpf_build.sv
sv/rchpf_tx.sv
sv/rc_hopping_packet_framer.sv
test/tb_rc_hopping_packet_framer.sv
